FILE: rtl/bba_pkg.sv
package bba_pkg;

  // Default configuration of the store.
  localparam int unsigned NumBlocksDef     = 256;
  localparam int unsigned BlockWordsDef    = 32;
  localparam int unsigned ReservedStartDef = 127;
  localparam int unsigned ReservedCountDef = 1;

  // Field widths of the transaction ports.
  localparam int unsigned OpW    = 3;
  localparam int unsigned BlkW   = 9;
  localparam int unsigned OffW   = 5;
  localparam int unsigned WordW  = 64;
  localparam int unsigned GrantW = 8;
  localparam int unsigned CountW = 9;

  // The allocation map is kept in rows of MapW bits.
  localparam int unsigned MapW = 32;
  localparam int unsigned BitW = 5;

  typedef enum logic [OpW-1:0] {
    OP_ALLOC   = 3'd0,
    OP_REQUEST = 3'd1,
    OP_RELEASE = 3'd2,
    OP_READ    = 3'd3,
    OP_WRITE   = 3'd4,
    OP_COUNTS  = 3'd5
  } opcode_e;

endpackage

FILE: rtl/bba_ram.sv
module bba_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 2
) (
  input  logic                                   clk_i,
  input  logic                                   we_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] addr_i,
  input  logic [WIDTH-1:0]                       wdata_i,
  output logic [WIDTH-1:0]                       rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end else begin
      rdata_q <= mem_q[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/bitmap_block_allocator_store.sv
// Block store of NUM_BLOCKS blocks of BLOCK_WORDS 64-bit words with a one-bit-per-block
// allocation map. Both the map (rows of 32 bits, with a per-row full flag used to pick the
// first row holding a free block) and the word store live in single-port RAMs with
// registered reads. An accepted transaction issues the map and word reads, is then checked
// and written back, and then loads the result register once the previous result is taken;
// it may wait there while the next transaction is accepted. After reset the block runs a
// clearing pass over every word address that zeroes the word store and loads the map with
// the reserved blocks marked used; no transaction is accepted until it ends.
module bitmap_block_allocator_store #(
  parameter int unsigned NUM_BLOCKS     = bba_pkg::NumBlocksDef,
  parameter int unsigned BLOCK_WORDS    = bba_pkg::BlockWordsDef,
  parameter int unsigned RESERVED_START = bba_pkg::ReservedStartDef,
  parameter int unsigned RESERVED_COUNT = bba_pkg::ReservedCountDef
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [bba_pkg::OpW-1:0]      opcode_i,
  input  logic [bba_pkg::BlkW-1:0]     block_index_i,
  input  logic [bba_pkg::OffW-1:0]     word_offset_i,
  input  logic [bba_pkg::WordW-1:0]    write_word_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic                         status_o,
  output logic [bba_pkg::GrantW-1:0]   granted_block_o,
  output logic [bba_pkg::WordW-1:0]    read_word_o,
  output logic [bba_pkg::CountW-1:0]   used_blocks_o,
  output logic [bba_pkg::CountW-1:0]   free_blocks_o
);
  import bba_pkg::*;

  localparam int unsigned ROWS    = (NUM_BLOCKS + MapW - 1) / MapW;
  localparam int unsigned ROW_W   = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int unsigned DEPTH   = NUM_BLOCKS * BLOCK_WORDS;
  localparam int unsigned ADDR_W  = $clog2(DEPTH);
  localparam int unsigned CNT_W   = $clog2(NUM_BLOCKS + 1);
  localparam int unsigned RES_END = (RESERVED_START + RESERVED_COUNT < NUM_BLOCKS) ?
                                    (RESERVED_START + RESERVED_COUNT) : NUM_BLOCKS;
  localparam int unsigned RES_N   = (RES_END > RESERVED_START) ? (RES_END - RESERVED_START) : 0;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_CHECK,
    ST_DONE
  } state_e;

  // Reset image of one map row: reserved blocks and padding past the last block are used.
  function automatic logic [MapW-1:0] init_row(logic [ROW_W-1:0] row);
    logic [MapW-1:0] v;
    int unsigned     b;
    for (int unsigned j = 0; j < MapW; j++) begin
      b    = 32'(row) * MapW + j;
      v[j] = (b >= NUM_BLOCKS) ||
             (b >= RESERVED_START && b < RESERVED_START + RESERVED_COUNT);
    end
    return v;
  endfunction

  state_e              state_q;
  logic [ADDR_W-1:0]   clr_q;
  opcode_e             op_q;
  logic                in_range_q, off_ok_q, resv_q, alloc_ok_q;
  logic [ROW_W-1:0]    row_q;
  logic [BitW-1:0]     bit_q;
  logic [ADDR_W-1:0]   daddr_q;
  logic [WordW-1:0]    wdata_q;
  logic [ROWS-1:0]     full_q;
  logic [CNT_W-1:0]    used_q;
  logic                res_status_q;
  logic [GrantW-1:0]   res_granted_q;
  logic [WordW-1:0]    res_rdata_q;
  logic                out_valid_q, status_q;
  logic [GrantW-1:0]   granted_q;
  logic [WordW-1:0]    rdata_q;
  logic [CountW-1:0]   used_out_q, free_out_q;

  logic                in_fire;
  logic [31:0]         blk32;
  logic                acc_in_range, acc_off_ok, acc_resv, any_free;
  logic [ROW_W-1:0]    free_row, acc_row;
  logic [ADDR_W-1:0]   acc_daddr;

  logic [MapW-1:0]     map_rdata, map_wdata, chk_row;
  logic [WordW-1:0]    data_rdata, data_wdata;
  logic [ROW_W-1:0]    map_addr;
  logic [ADDR_W-1:0]   data_addr;
  logic                map_we, data_we;
  logic                clr_map;

  logic                cur_used, chk_map_we, chk_data_we, chk_status;
  logic [BitW-1:0]     ffz;
  logic [GrantW-1:0]   chk_granted;
  logic [WordW-1:0]    chk_rdata;
  logic [CNT_W-1:0]    used_d;

  // Acceptance: decode the request and pick the map row to read.
  assign in_ready_o = (state_q == ST_IDLE);
  assign in_fire    = in_valid_i && in_ready_o;
  assign blk32      = 32'(block_index_i);

  assign acc_in_range = blk32 < NUM_BLOCKS;
  assign acc_off_ok   = 32'(word_offset_i) < BLOCK_WORDS;
  assign acc_resv     = (blk32 >= RESERVED_START) && (blk32 < RESERVED_START + RESERVED_COUNT);
  assign any_free     = ~&full_q;
  assign acc_row      = (opcode_e'(opcode_i) == OP_ALLOC) ? free_row : ROW_W'(blk32 >> BitW);
  assign acc_daddr    = ADDR_W'(blk32 * BLOCK_WORDS + 32'(word_offset_i));

  always_comb begin
    free_row = '0;
    for (int r = ROWS - 1; r >= 0; r--) begin
      if (!full_q[r]) begin
        free_row = ROW_W'(r);
      end
    end
  end

  // Check and write back, with the map row and the word read in the previous cycle.
  assign cur_used = map_rdata[bit_q];

  always_comb begin
    ffz = '0;
    for (int j = MapW - 1; j >= 0; j--) begin
      if (!map_rdata[j]) begin
        ffz = BitW'(j);
      end
    end
  end

  always_comb begin
    chk_row     = map_rdata;
    chk_map_we  = 1'b0;
    chk_data_we = 1'b0;
    chk_status  = 1'b0;
    chk_granted = '0;
    chk_rdata   = '0;
    used_d      = used_q;
    case (op_q)
      OP_ALLOC: begin
        if (alloc_ok_q) begin
          chk_row[ffz] = 1'b1;
          chk_map_we   = 1'b1;
          used_d       = used_q + CNT_W'(1);
          chk_granted  = GrantW'((32'(row_q) << BitW) | 32'(ffz));
        end else begin
          chk_status = 1'b1;
        end
      end
      OP_REQUEST: begin
        if (!in_range_q || cur_used) begin
          chk_status = 1'b1;
        end else begin
          chk_row[bit_q] = 1'b1;
          chk_map_we     = 1'b1;
          used_d         = used_q + CNT_W'(1);
        end
      end
      OP_RELEASE: begin
        if (in_range_q && !resv_q && cur_used) begin
          chk_row[bit_q] = 1'b0;
          chk_map_we     = 1'b1;
          used_d         = used_q - CNT_W'(1);
        end
      end
      OP_READ: begin
        if (!in_range_q || !off_ok_q || !cur_used) begin
          chk_status = 1'b1;
        end else begin
          chk_rdata = data_rdata;
        end
      end
      OP_WRITE: begin
        if (!in_range_q || !off_ok_q || !cur_used || resv_q) begin
          chk_status = 1'b1;
        end else begin
          chk_data_we = 1'b1;
        end
      end
      OP_COUNTS: begin
        chk_status = 1'b0;
      end
      default: begin
        chk_status = 1'b1;
      end
    endcase
  end

  // Memory ports.
  assign clr_map = (state_q == ST_CLEAR) && (32'(clr_q) < ROWS);

  always_comb begin
    unique case (state_q)
      ST_CLEAR: begin
        map_addr  = ROW_W'(clr_q);
        data_addr = clr_q;
      end
      ST_IDLE: begin
        map_addr  = acc_row;
        data_addr = acc_daddr;
      end
      default: begin
        map_addr  = row_q;
        data_addr = daddr_q;
      end
    endcase
  end

  assign map_we     = clr_map || ((state_q == ST_CHECK) && chk_map_we);
  assign map_wdata  = (state_q == ST_CLEAR) ? init_row(ROW_W'(clr_q)) : chk_row;
  assign data_we    = (state_q == ST_CLEAR) || ((state_q == ST_CHECK) && chk_data_we);
  assign data_wdata = (state_q == ST_CLEAR) ? '0 : wdata_q;

  bba_ram #(
    .WIDTH (MapW),
    .DEPTH (ROWS)
  ) u_map_ram (
    .clk_i   (clk_i),
    .we_i    (map_we),
    .addr_i  (map_addr),
    .wdata_i (map_wdata),
    .rdata_o (map_rdata)
  );

  bba_ram #(
    .WIDTH (WordW),
    .DEPTH (DEPTH)
  ) u_data_ram (
    .clk_i   (clk_i),
    .we_i    (data_we),
    .addr_i  (data_addr),
    .wdata_i (data_wdata),
    .rdata_o (data_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_q       <= '0;
      full_q      <= '0;
      used_q      <= CNT_W'(RES_N);
      out_valid_q <= 1'b0;
    end else begin
      // In ST_DONE the result register is handled below.
      if (out_ready_i && (state_q != ST_DONE)) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_CLEAR: begin
          if (clr_map) begin
            full_q[ROW_W'(clr_q)] <= &init_row(ROW_W'(clr_q));
          end
          if (clr_q == ADDR_W'(DEPTH - 1)) begin
            state_q <= ST_IDLE;
          end
          clr_q <= clr_q + ADDR_W'(1);
        end
        ST_IDLE: begin
          if (in_fire) begin
            op_q       <= opcode_e'(opcode_i);
            in_range_q <= acc_in_range;
            off_ok_q   <= acc_off_ok;
            resv_q     <= acc_resv;
            alloc_ok_q <= any_free;
            row_q      <= acc_row;
            bit_q      <= block_index_i[BitW-1:0];
            daddr_q    <= acc_daddr;
            wdata_q    <= write_word_i;
            state_q    <= ST_CHECK;
          end
        end
        ST_CHECK: begin
          if (chk_map_we) begin
            full_q[row_q] <= &chk_row;
          end
          used_q        <= used_d;
          res_status_q  <= chk_status;
          res_granted_q <= chk_granted;
          res_rdata_q   <= chk_rdata;
          state_q       <= ST_DONE;
        end
        ST_DONE: begin
          // The result register may still hold the previous transaction.
          if (!out_valid_q || out_ready_i) begin
            out_valid_q <= 1'b1;
            status_q    <= res_status_q;
            granted_q   <= res_granted_q;
            rdata_q     <= res_rdata_q;
            used_out_q  <= CountW'(used_q);
            free_out_q  <= CountW'(CNT_W'(NUM_BLOCKS) - used_q);
            state_q     <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_valid_o     = out_valid_q;
  assign status_o        = status_q;
  assign granted_block_o = granted_q;
  assign read_word_o     = rdata_q;
  assign used_blocks_o   = used_out_q;
  assign free_blocks_o   = free_out_q;

endmodule

FILE: bench/tb_bitmap_block_allocator_store.sv
`timescale 1ns / 1ps

module tb_bitmap_block_allocator_store;
  import bba_pkg::*;

  localparam int unsigned NumBlk    = NumBlocksDef;
  localparam int unsigned BlkWords  = BlockWordsDef;
  localparam int unsigned ResvStart = ReservedStartDef;
  localparam int unsigned ResvCount = ReservedCountDef;
  localparam int unsigned BlkMax    = (1 << BlkW) - 1;
  localparam int unsigned OffMax    = (1 << OffW) - 1;

  // Opcodes outside the defined set.
  localparam logic [OpW-1:0] OpSpare6 = 3'd6;
  localparam logic [OpW-1:0] OpSpare7 = 3'd7;

  typedef struct {
    logic [OpW-1:0]   opcode;
    logic [BlkW-1:0]  blk;
    logic [OffW-1:0]  off;
    logic [WordW-1:0] wdata;
  } store_op_t;

  typedef struct {
    logic              status;
    logic [GrantW-1:0] granted;
    logic [WordW-1:0]  rdata;
    logic [CountW-1:0] used_cnt;
    logic [CountW-1:0] free_cnt;
  } store_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic              in_valid = 1'b0;
  logic              in_ready;
  logic [OpW-1:0]    opcode = '0;
  logic [BlkW-1:0]   blk_idx = '0;
  logic [OffW-1:0]   word_off = '0;
  logic [WordW-1:0]  wr_word = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic              status;
  logic [GrantW-1:0] granted_block;
  logic [WordW-1:0]  rd_word;
  logic [CountW-1:0] used_blocks;
  logic [CountW-1:0] free_blocks;

  // Shadow copy of the allocation map and the word store.
  bit              blk_used [NumBlk];
  bit [WordW-1:0]  blk_words [NumBlk*BlkWords];
  int unsigned     used_count;

  store_op_t       op_queue[$];
  store_result_t   expected_results[$];
  int unsigned     sent_cnt = 0;
  int unsigned     taken_cnt = 0;
  int unsigned     send_gap = 0;
  int unsigned     stall_left = 0;
  int unsigned     mismatches = 0;
  bit              no_idle = 1'b0;

  bitmap_block_allocator_store dut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .in_valid_i      (in_valid),
    .in_ready_o      (in_ready),
    .opcode_i        (opcode),
    .block_index_i   (blk_idx),
    .word_offset_i   (word_off),
    .write_word_i    (wr_word),
    .out_valid_o     (out_valid),
    .out_ready_i     (out_ready),
    .status_o        (status),
    .granted_block_o (granted_block),
    .read_word_o     (rd_word),
    .used_blocks_o   (used_blocks),
    .free_blocks_o   (free_blocks)
  );

  always #5 clk = ~clk;

  function automatic bit reserved_blk(int unsigned b);
    return b >= ResvStart && b < ResvStart + ResvCount;
  endfunction

  function automatic store_result_t apply_store_op(store_op_t op);
    store_result_t res;
    bit            in_range;
    bit            off_ok;
    bit            hit;
    int unsigned   idx;
    res = '{status: 1'b0, granted: '0, rdata: '0, used_cnt: '0, free_cnt: '0};
    in_range = op.blk < NumBlk;
    off_ok = op.off < BlkWords;
    idx = op.blk * BlkWords + op.off;
    hit = 1'b0;
    case (op.opcode)
      OP_ALLOC: begin
        res.status = 1'b1;
        for (int unsigned b = 0; b < NumBlk && !hit; b++) begin
          if (!blk_used[b]) begin
            blk_used[b] = 1'b1;
            used_count++;
            res.granted = GrantW'(b);
            res.status = 1'b0;
            hit = 1'b1;
          end
        end
      end
      OP_REQUEST: begin
        if (!in_range || blk_used[op.blk]) begin
          res.status = 1'b1;
        end else begin
          blk_used[op.blk] = 1'b1;
          used_count++;
        end
      end
      OP_RELEASE: begin
        // Reserved, free and out-of-range blocks are left alone without a failure.
        if (in_range && !reserved_blk(op.blk) && blk_used[op.blk]) begin
          blk_used[op.blk] = 1'b0;
          used_count--;
        end
      end
      OP_READ: begin
        if (!in_range || !off_ok || !blk_used[op.blk]) begin
          res.status = 1'b1;
        end else begin
          res.rdata = blk_words[idx];
        end
      end
      OP_WRITE: begin
        if (!in_range || !off_ok || !blk_used[op.blk] || reserved_blk(op.blk)) begin
          res.status = 1'b1;
        end else begin
          blk_words[idx] = op.wdata;
        end
      end
      OP_COUNTS: begin
      end
      default: begin
        res.status = 1'b1;
      end
    endcase
    res.used_cnt = CountW'(used_count);
    res.free_cnt = CountW'(NumBlk - used_count);
    return res;
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned r;
    if (no_idle) begin
      return 0;
    end
    r = $urandom_range(99);
    if (r < 55) begin
      return 0;
    end else if (r < 90) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(8, 40);
  endfunction

  task automatic queue_op(logic [OpW-1:0] op, int unsigned b, int unsigned o,
                          logic [WordW-1:0] d);
    op_queue.push_back('{opcode: op, blk: BlkW'(b), off: OffW'(o), wdata: d});
  endtask

  // Weights are percentages; what is left over goes to counts and the spare opcodes.
  task automatic queue_random_ops(int unsigned count, int unsigned w_alloc,
                                  int unsigned w_req, int unsigned w_rel,
                                  int unsigned w_rd, int unsigned w_wr);
    int unsigned      r;
    int unsigned      b;
    int unsigned      o;
    logic [OpW-1:0]   op;
    logic [WordW-1:0] d;
    for (int unsigned i = 0; i < count; i++) begin
      r = $urandom_range(99);
      if (r < w_alloc) begin
        op = OP_ALLOC;
      end else if (r < w_alloc + w_req) begin
        op = OP_REQUEST;
      end else if (r < w_alloc + w_req + w_rel) begin
        op = OP_RELEASE;
      end else if (r < w_alloc + w_req + w_rel + w_rd) begin
        op = OP_READ;
      end else if (r < w_alloc + w_req + w_rel + w_rd + w_wr) begin
        op = OP_WRITE;
      end else if (r == 98) begin
        op = OpSpare6;
      end else if (r == 99) begin
        op = OpSpare7;
      end else begin
        op = OP_COUNTS;
      end
      r = $urandom_range(99);
      if (r < 10) begin
        b = $urandom_range(NumBlk, BlkMax);
      end else if (r < 14) begin
        b = ResvStart;
      end else if (r < 45) begin
        b = $urandom_range(0, 15);
      end else begin
        b = $urandom_range(0, NumBlk - 1);
      end
      // A small working set of offsets lets reads find earlier writes.
      o = ($urandom_range(9) < 6) ? $urandom_range(0, 3) : $urandom_range(0, OffMax);
      r = $urandom_range(9);
      if (r == 0) begin
        d = '1;
      end else if (r == 1) begin
        d = '0;
      end else begin
        d = {$urandom, $urandom};
      end
      queue_op(op, b, o, d);
    end
  endtask

  // Sender side.
  always @(negedge clk) begin
    store_op_t nxt;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (in_valid && taken_cnt != sent_cnt) begin
      in_valid <= 1'b1;
    end else if (send_gap > 0) begin
      send_gap--;
      in_valid <= 1'b0;
    end else if (op_queue.size() > 0) begin
      nxt = op_queue.pop_front();
      opcode <= nxt.opcode;
      blk_idx <= nxt.blk;
      word_off <= nxt.off;
      wr_word <= nxt.wdata;
      in_valid <= 1'b1;
      sent_cnt++;
      send_gap = pick_gap();
    end else begin
      in_valid <= 1'b0;
    end
  end

  // Receiver side.
  always @(negedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
      stall_left = pick_gap();
    end
  end

  always @(posedge clk) begin
    store_op_t     taken_op;
    store_result_t got;
    store_result_t want;
    if (rst_n) begin
      if (in_valid && in_ready) begin
        taken_op = '{opcode: opcode, blk: blk_idx, off: word_off, wdata: wr_word};
        expected_results.push_back(apply_store_op(taken_op));
        taken_cnt++;
      end
      if (out_valid && out_ready) begin
        got = '{status: status, granted: granted_block, rdata: rd_word,
                used_cnt: used_blocks, free_cnt: free_blocks};
        if (expected_results.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("unexpected transaction: status %0d granted %0d read %h used %0d free %0d",
                     got.status, got.granted, got.rdata, got.used_cnt, got.free_cnt);
          end
        end else begin
          want = expected_results.pop_front();
          if (got.status !== want.status || got.granted !== want.granted ||
              got.rdata !== want.rdata || got.used_cnt !== want.used_cnt ||
              got.free_cnt !== want.free_cnt) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("mismatch: expected status %0d granted %0d read %h used %0d free %0d",
                       want.status, want.granted, want.rdata, want.used_cnt, want.free_cnt);
              $display("          got      status %0d granted %0d read %h used %0d free %0d",
                       got.status, got.granted, got.rdata, got.used_cnt, got.free_cnt);
            end
          end
        end
      end
    end
  end

  initial begin
    used_count = 0;
    for (int unsigned b = 0; b < NumBlk; b++) begin
      blk_used[b] = reserved_blk(b);
      if (reserved_blk(b)) begin
        used_count++;
      end
    end

    queue_op(OP_COUNTS, 0, 0, '0);
    queue_op(OP_ALLOC, 0, 0, '0);
    queue_op(OP_ALLOC, BlkMax, OffMax, '1);
    queue_op(OP_REQUEST, 0, 0, '0);
    queue_op(OP_REQUEST, ResvStart, 0, '0);
    queue_op(OP_REQUEST, BlkMax, 0, '0);
    queue_op(OP_REQUEST, NumBlk, 0, '0);
    queue_op(OP_REQUEST, NumBlk - 1, 0, '0);
    queue_op(OP_WRITE, 0, 0, '1);
    queue_op(OP_WRITE, 0, OffMax, 64'h0123_4567_89ab_cdef);
    queue_op(OP_READ, 0, 0, '0);
    queue_op(OP_READ, 0, OffMax, '0);
    queue_op(OP_WRITE, NumBlk - 1, 17, 64'h8000_0000_0000_0001);
    queue_op(OP_READ, NumBlk - 1, 17, '0);
    queue_op(OP_READ, ResvStart, 0, '0);
    queue_op(OP_WRITE, ResvStart, 0, '1);
    queue_op(OP_WRITE, 5, 3, '1);
    queue_op(OP_READ, 5, 3, '0);
    queue_op(OP_RELEASE, ResvStart, 0, '0);
    queue_op(OP_RELEASE, 5, 0, '0);
    queue_op(OP_RELEASE, BlkMax, 0, '0);
    queue_op(OP_RELEASE, 1, 0, '0);
    queue_op(OP_READ, 1, 0, '0);
    queue_op(OP_WRITE, 300, 9, '1);
    queue_op(OpSpare6, 0, 0, '0);
    queue_op(OpSpare7, 0, 0, '0);
    queue_op(OP_COUNTS, 0, 0, '0);

    // Allocation-heavy mix that runs the store full and keeps allocating.
    queue_random_ops(380, 70, 8, 2, 8, 8);

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Hold off the sender until every result of the fill has come back.
    while (op_queue.size() > 0 || in_valid || expected_results.size() > 0) begin
      @(posedge clk);
    end

    // Release-heavy churn, opening with a stretch that has no idle cycles.
    no_idle = 1'b1;
    queue_random_ops(300, 12, 10, 28, 22, 23);
    while (op_queue.size() > 200) begin
      @(posedge clk);
    end
    no_idle = 1'b0;

    while (op_queue.size() > 0 || in_valid || expected_results.size() > 0) begin
      @(posedge clk);
    end
    repeat (20) @(posedge clk);
    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin
    #3ms;
    $display("tb: failure");
    $finish;
  end

endmodule

FILE: bitmap_block_allocator_store.f
rtl/bba_pkg.sv
rtl/bba_ram.sv
rtl/bitmap_block_allocator_store.sv
bench/tb_bitmap_block_allocator_store.sv
